// File: hw/rtl/ostw_pkg.sv
// Shared types and constants of the onset score time warper.
package ostw_pkg;

    localparam int TIME_W = 24;
    localparam int NOTE_W = 15;

    localparam logic [1:0] CFG_BKPT_COUNT   = 2'd0;
    localparam logic [1:0] CFG_FORGET_WIN   = 2'd1;
    localparam logic [1:0] CFG_SEARCH_RANGE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FG_RD,
        ST_FG_CHK,
        ST_SK_RD,
        ST_SK_CHK,
        ST_CL_RD,
        ST_CL_CHK,
        ST_K_RD,
        ST_K_DAT,
        ST_B_RD,
        ST_B_CHK,
        ST_HYP_END,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_PUSH,
        OP_FG_RD,
        OP_FG_POP,
        OP_REALIGN_INIT,
        OP_BK_RD,
        OP_I_INC,
        OP_HYP_INIT,
        OP_MS_RD,
        OP_MS_LATCH,
        OP_BI_RD,
        OP_BI_DEC,
        OP_SCORE,
        OP_HYP_END,
        OP_COMMIT,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_meas;
        logic too_old;
        logic onset;
        logic i_at_end;
        logic skip_early;
        logic in_range;
        logic bk_pitched;
        logic k_at_end;
        logic b_earlier;
        logic bi_zero;
        logic out_busy;
    } stat_t;

endpackage

// File: hw/rtl/onset_score_time_warper_unit.sv
// Top level of the onset score time warper: sequencer plus datapath.
//
// This block follows a performer through a score. A load item (req_type 0)
// writes one breakpoint of the score table; a measurement item (req_type 1)
// enters a ring of recent playhead measurements and always returns one result
// item carrying the warped score time, a flag that tells whether a new match
// was chosen, and the index of the current match. Entries older than
// forget_window are dropped from the ring, oldest first. At an onset, a pitched
// measurement following an unpitched one, every pitched breakpoint within
// search_range of the playhead is scored against the ring, and the first best
// one becomes the match. All work runs on one sequencer that reads the
// breakpoint memory and the ring through single registered read ports, so
// the cost of an item is counted in those reads. A measurement item reads
// the ring head once more for each entry dropped; at an onset it reads one
// breakpoint for each breakpoint scanned and, for each hypothesis, one ring
// read for each measurement compared and one breakpoint read for each
// breakpoint it steps through. The input stalls while an item is in
// progress; a finished result waits in the output register while the next
// item is taken. Configuration writes are always ready and must be made
// while the block is idle. Breakpoints that were never loaded must not be
// referenced by breakpoint_count.
module onset_score_time_warper_unit
#(
    parameter int BKPT_DEPTH = 256,
    parameter int MEAS_DEPTH = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [ostw_pkg::TIME_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [7:0]                  entry_index,
    input  logic [ostw_pkg::TIME_W-1:0] event_time,
    input  logic                        is_pitched,
    input  logic [ostw_pkg::NOTE_W-1:0] note_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ostw_pkg::TIME_W-1:0] warped_time,
    output logic                        realigned,
    output logic [7:0]                  match_index
);

    ostw_pkg::cmd_t  cmd;
    ostw_pkg::stat_t stat;

    // Register writes go straight into the configuration registers, so the port never pushes back.
    assign cfg_ready = 1'b1;

    ostw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ostw_datapath
    #(
        .BKPT_DEPTH (BKPT_DEPTH),
        .MEAS_DEPTH (MEAS_DEPTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .entry_index (entry_index),
        .event_time  (event_time),
        .is_pitched  (is_pitched),
        .note_value  (note_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .warped_time (warped_time),
        .realigned   (realigned),
        .match_index (match_index)
    );

endmodule

// File: hw/rtl/ostw_ctrl.sv
// Sequencer of the onset score time warper.
module ostw_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ostw_pkg::stat_t stat,
    output ostw_pkg::cmd_t  cmd
);

    ostw_pkg::state_t state_reg;
    ostw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ostw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ostw_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = ostw_pkg::OP_NONE;
        unique case (state_reg)
            ostw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = ostw_pkg::OP_CAPTURE;
                    state_next = ostw_pkg::ST_DISPATCH;
                end
            end
            ostw_pkg::ST_DISPATCH:
            begin
                if (stat.is_meas)
                begin
                    cmd.op     = ostw_pkg::OP_PUSH;
                    state_next = ostw_pkg::ST_FG_RD;
                end
                else
                begin
                    cmd.op     = ostw_pkg::OP_LOAD;
                    state_next = ostw_pkg::ST_IDLE;
                end
            end
            ostw_pkg::ST_FG_RD:
            begin
                cmd.op     = ostw_pkg::OP_FG_RD;
                state_next = ostw_pkg::ST_FG_CHK;
            end
            ostw_pkg::ST_FG_CHK:
            begin
                if (stat.too_old)
                begin
                    cmd.op     = ostw_pkg::OP_FG_POP;
                    state_next = ostw_pkg::ST_FG_RD;
                end
                else if (stat.onset)
                begin
                    cmd.op     = ostw_pkg::OP_REALIGN_INIT;
                    state_next = ostw_pkg::ST_SK_RD;
                end
                else
                begin
                    state_next = ostw_pkg::ST_FINISH;
                end
            end
            ostw_pkg::ST_SK_RD:
            begin
                if (stat.i_at_end)
                begin
                    state_next = ostw_pkg::ST_COMMIT;
                end
                else
                begin
                    cmd.op     = ostw_pkg::OP_BK_RD;
                    state_next = ostw_pkg::ST_SK_CHK;
                end
            end
            ostw_pkg::ST_SK_CHK:
            begin
                if (stat.skip_early)
                begin
                    cmd.op     = ostw_pkg::OP_I_INC;
                    state_next = ostw_pkg::ST_SK_RD;
                end
                else
                begin
                    state_next = ostw_pkg::ST_CL_CHK;
                end
            end
            ostw_pkg::ST_CL_RD:
            begin
                if (stat.i_at_end)
                begin
                    state_next = ostw_pkg::ST_COMMIT;
                end
                else
                begin
                    cmd.op     = ostw_pkg::OP_BK_RD;
                    state_next = ostw_pkg::ST_CL_CHK;
                end
            end
            ostw_pkg::ST_CL_CHK:
            begin
                if (!stat.in_range)
                begin
                    state_next = ostw_pkg::ST_COMMIT;
                end
                else if (stat.bk_pitched)
                begin
                    cmd.op     = ostw_pkg::OP_HYP_INIT;
                    state_next = ostw_pkg::ST_K_RD;
                end
                else
                begin
                    cmd.op     = ostw_pkg::OP_I_INC;
                    state_next = ostw_pkg::ST_CL_RD;
                end
            end
            ostw_pkg::ST_K_RD:
            begin
                if (stat.k_at_end)
                begin
                    state_next = ostw_pkg::ST_HYP_END;
                end
                else
                begin
                    cmd.op     = ostw_pkg::OP_MS_RD;
                    state_next = ostw_pkg::ST_K_DAT;
                end
            end
            ostw_pkg::ST_K_DAT:
            begin
                cmd.op     = ostw_pkg::OP_MS_LATCH;
                state_next = ostw_pkg::ST_B_RD;
            end
            ostw_pkg::ST_B_RD:
            begin
                cmd.op     = ostw_pkg::OP_BI_RD;
                state_next = ostw_pkg::ST_B_CHK;
            end
            ostw_pkg::ST_B_CHK:
            begin
                if (stat.b_earlier)
                begin
                    if (stat.bi_zero)
                    begin
                        state_next = ostw_pkg::ST_HYP_END;
                    end
                    else
                    begin
                        cmd.op     = ostw_pkg::OP_BI_DEC;
                        state_next = ostw_pkg::ST_B_RD;
                    end
                end
                else
                begin
                    cmd.op     = ostw_pkg::OP_SCORE;
                    state_next = ostw_pkg::ST_K_RD;
                end
            end
            ostw_pkg::ST_HYP_END:
            begin
                cmd.op     = ostw_pkg::OP_HYP_END;
                state_next = ostw_pkg::ST_CL_RD;
            end
            ostw_pkg::ST_COMMIT:
            begin
                cmd.op     = ostw_pkg::OP_COMMIT;
                state_next = ostw_pkg::ST_FINISH;
            end
            ostw_pkg::ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = ostw_pkg::OP_RESULT;
                    state_next = ostw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ostw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ostw_datapath.sv
// Datapath of the onset score time warper: tables, ring, scoring and result.
module ostw_datapath
#(
    parameter int BKPT_DEPTH = 256,
    parameter int MEAS_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ostw_pkg::cmd_t                cmd,
    output ostw_pkg::stat_t               stat,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [ostw_pkg::TIME_W-1:0]   cfg_data,
    input  logic                          req_type,
    input  logic [7:0]                    entry_index,
    input  logic [ostw_pkg::TIME_W-1:0]   event_time,
    input  logic                          is_pitched,
    input  logic [ostw_pkg::NOTE_W-1:0]   note_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ostw_pkg::TIME_W-1:0]   warped_time,
    output logic                          realigned,
    output logic [7:0]                    match_index
);

    localparam int BW = (BKPT_DEPTH > 1) ? $clog2(BKPT_DEPTH) : 1;
    localparam int MW = (MEAS_DEPTH > 1) ? $clog2(MEAS_DEPTH) : 1;
    localparam int SW = $clog2(MEAS_DEPTH + 1) + 10;
    localparam int TW = ostw_pkg::TIME_W;

    // Storage.
    logic [TW-1:0] bkpt_time_mem [BKPT_DEPTH];
    logic [7:0]    bkpt_note_mem [BKPT_DEPTH];
    logic [TW-1:0] meas_time_mem [MEAS_DEPTH];
    logic [15:0]   meas_note_mem [MEAS_DEPTH];

    logic [TW-1:0] bt_q;
    logic [7:0]    bn_q;
    logic [TW-1:0] mt_q;
    logic [15:0]   mn_q;

    // Configuration.
    logic [8:0]    bcount_reg;
    logic [TW-1:0] fwin_reg;
    logic [TW-1:0] srange_reg;

    // Captured item.
    logic                      type_reg;
    logic [7:0]                idx_reg;
    logic [TW-1:0]             now_reg;
    logic                      pitch_reg;
    logic [ostw_pkg::NOTE_W-1:0] note_reg;

    // Persistent state.
    logic [MW-1:0] head_reg;
    logic [MW:0]   fill_reg;
    logic          prev_reg;
    logic [TW-1:0] match_time_reg;
    logic [TW-1:0] change_reg;
    logic [BW-1:0] winner_reg;

    // Search state.
    logic [BW:0]   i_reg;
    logic [BW-1:0] h_reg;
    logic [BW-1:0] bi_reg;
    logic [TW-1:0] end_t_reg;
    logic [MW:0]   k_reg;
    logic [SW-1:0] score_reg;
    logic [SW-1:0] best_reg;
    logic [BW-1:0] best_idx_reg;
    logic [TW-1:0] best_t_reg;
    logic          found_reg;
    logic          re_reg;
    logic signed [TW+1:0] offset_reg;
    logic [15:0]   mn_cur_reg;

    // Combinational helpers.
    logic [BW:0]   n_lim;
    logic          full;
    logic [MW:0]   push_sum;
    logic [MW-1:0] push_slot;
    logic [MW:0]   back_cnt;
    logic [MW:0]   ms_sum;
    logic [MW-1:0] ms_slot;
    logic [MW-1:0] head_inc;
    logic [BW-1:0] bk_addr;
    logic [MW-1:0] ring_addr;
    logic signed [TW+1:0] s_now;
    logic signed [TW+1:0] s_bt;
    logic signed [TW+1:0] s_mt;
    logic signed [TW+1:0] s_end;
    logic signed [TW+1:0] s_fwin;
    logic signed [TW+1:0] s_srange;
    logic          mp;
    logic          fp;
    logic [14:0]   a_note;
    logic [14:0]   b_note;
    logic [14:0]   d_note;
    logic [10:0]   add_val;
    logic signed [TW+2:0] w_sum;
    logic [TW-1:0] w_sat;

    always_comb
    begin
        if (32'(bcount_reg) >= BKPT_DEPTH)
        begin
            n_lim = (BW+1)'(BKPT_DEPTH);
        end
        else
        begin
            n_lim = (BW+1)'(bcount_reg);
        end
    end

    assign full      = (fill_reg >= (MW+1)'(MEAS_DEPTH));
    assign push_sum  = {1'b0, head_reg} + fill_reg;
    assign push_slot = full ? head_reg
                     : (push_sum >= (MW+1)'(MEAS_DEPTH))
                       ? MW'(push_sum - (MW+1)'(MEAS_DEPTH)) : MW'(push_sum);
    assign back_cnt  = fill_reg - (MW+1)'(1) - k_reg;
    assign ms_sum    = {1'b0, head_reg} + back_cnt;
    assign ms_slot   = (ms_sum >= (MW+1)'(MEAS_DEPTH))
                       ? MW'(ms_sum - (MW+1)'(MEAS_DEPTH)) : MW'(ms_sum);
    assign head_inc  = (32'(head_reg) == MEAS_DEPTH - 1) ? '0 : head_reg + MW'(1);

    assign bk_addr   = (cmd.op == ostw_pkg::OP_BK_RD) ? BW'(i_reg) : bi_reg;
    assign ring_addr = (cmd.op == ostw_pkg::OP_FG_RD) ? head_reg : ms_slot;

    assign s_now    = $signed({2'b00, now_reg});
    assign s_bt     = $signed({2'b00, bt_q});
    assign s_mt     = $signed({2'b00, mt_q});
    assign s_end    = $signed({2'b00, end_t_reg});
    assign s_fwin   = $signed({2'b00, fwin_reg});
    assign s_srange = $signed({2'b00, srange_reg});

    // Per-pair similarity in units of 1/512.
    assign mp     = mn_cur_reg[15];
    assign fp     = bn_q[7];
    assign a_note = mn_cur_reg[14:0];
    assign b_note = {bn_q[6:0], 8'h00};
    assign d_note = (a_note > b_note) ? (a_note - b_note) : (b_note - a_note);

    always_comb
    begin
        add_val = '0;
        if (mp == fp)
        begin
            add_val = 11'd512;
        end
        if (mp && fp && (d_note < 15'd512))
        begin
            add_val = add_val + (11'd512 - 11'(d_note));
        end
    end

    assign w_sum = $signed({3'b000, match_time_reg}) + $signed({3'b000, now_reg})
                 - $signed({3'b000, change_reg});

    always_comb
    begin
        if (w_sum < 0)
        begin
            w_sat = '0;
        end
        else if (w_sum > $signed({3'b000, {TW{1'b1}}}))
        begin
            w_sat = {TW{1'b1}};
        end
        else
        begin
            w_sat = TW'(w_sum);
        end
    end

    always_comb
    begin
        stat.is_meas    = type_reg;
        stat.too_old    = (fill_reg != '0) && ((s_now - s_mt) > s_fwin);
        stat.onset      = pitch_reg && !prev_reg;
        stat.i_at_end   = (i_reg >= n_lim);
        stat.skip_early = ((s_now - s_bt) > s_srange);
        stat.in_range   = ((s_bt - s_now) <= s_srange);
        stat.bk_pitched = bn_q[7];
        stat.k_at_end   = (k_reg >= fill_reg);
        stat.b_earlier  = ((s_end - s_bt) < offset_reg);
        stat.bi_zero    = (bi_reg == '0);
        stat.out_busy   = out_valid && out_stall;
    end

    // Breakpoint tables.
    always_ff @(posedge clk)
    begin
        if ((cmd.op == ostw_pkg::OP_LOAD) && (32'(idx_reg) < BKPT_DEPTH))
        begin
            bkpt_time_mem[BW'(idx_reg)] <= now_reg;
            bkpt_note_mem[BW'(idx_reg)] <= {pitch_reg, note_reg[14:8]};
        end
        if ((cmd.op == ostw_pkg::OP_BK_RD) || (cmd.op == ostw_pkg::OP_BI_RD))
        begin
            bt_q <= bkpt_time_mem[bk_addr];
            bn_q <= bkpt_note_mem[bk_addr];
        end
    end

    // Measurement ring.
    always_ff @(posedge clk)
    begin
        if (cmd.op == ostw_pkg::OP_PUSH)
        begin
            meas_time_mem[push_slot] <= now_reg;
            meas_note_mem[push_slot] <= {pitch_reg, note_reg};
        end
        if ((cmd.op == ostw_pkg::OP_FG_RD) || (cmd.op == ostw_pkg::OP_MS_RD))
        begin
            mt_q <= meas_time_mem[ring_addr];
            mn_q <= meas_note_mem[ring_addr];
        end
    end

    // Payload registers of the captured item and of the search.
    always_ff @(posedge clk)
    begin
        if (cmd.op == ostw_pkg::OP_CAPTURE)
        begin
            type_reg  <= req_type;
            idx_reg   <= entry_index;
            now_reg   <= event_time;
            pitch_reg <= is_pitched;
            note_reg  <= note_value;
        end
        if (cmd.op == ostw_pkg::OP_HYP_INIT)
        begin
            h_reg     <= BW'(i_reg);
            end_t_reg <= bt_q;
            score_reg <= '0;
        end
        if (cmd.op == ostw_pkg::OP_MS_LATCH)
        begin
            offset_reg <= s_now - s_mt;
            mn_cur_reg <= mn_q;
        end
        if (cmd.op == ostw_pkg::OP_SCORE)
        begin
            score_reg <= score_reg + SW'(add_val);
        end
        if ((cmd.op == ostw_pkg::OP_HYP_END) && (!found_reg || (score_reg > best_reg)))
        begin
            best_reg     <= score_reg;
            best_idx_reg <= h_reg;
            best_t_reg   <= end_t_reg;
        end
        if (cmd.op == ostw_pkg::OP_HYP_INIT)
        begin
            bi_reg <= BW'(i_reg);
        end
        else if (cmd.op == ostw_pkg::OP_BI_DEC)
        begin
            bi_reg <= bi_reg - BW'(1);
        end
    end

    // Configuration, control state and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg     <= '0;
            fwin_reg       <= TW'(768);
            srange_reg     <= TW'(256);
            head_reg       <= '0;
            fill_reg       <= '0;
            prev_reg       <= 1'b0;
            match_time_reg <= '0;
            change_reg     <= '0;
            winner_reg     <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            found_reg      <= 1'b0;
            re_reg         <= 1'b0;
            out_valid      <= 1'b0;
            warped_time    <= '0;
            realigned      <= 1'b0;
            match_index    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ostw_pkg::CFG_BKPT_COUNT:   bcount_reg <= cfg_data[8:0];
                    ostw_pkg::CFG_FORGET_WIN:   fwin_reg   <= cfg_data;
                    ostw_pkg::CFG_SEARCH_RANGE: srange_reg <= cfg_data;
                    default:                    ;
                endcase
            end
            if (out_valid && !out_stall && (cmd.op != ostw_pkg::OP_RESULT))
            begin
                out_valid <= 1'b0;
            end
            case (cmd.op)
                ostw_pkg::OP_CAPTURE:
                begin
                    re_reg <= 1'b0;
                end
                ostw_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        head_reg <= head_inc;
                    end
                    else
                    begin
                        fill_reg <= fill_reg + (MW+1)'(1);
                    end
                end
                ostw_pkg::OP_FG_POP:
                begin
                    head_reg <= head_inc;
                    fill_reg <= fill_reg - (MW+1)'(1);
                end
                ostw_pkg::OP_REALIGN_INIT:
                begin
                    i_reg     <= '0;
                    found_reg <= 1'b0;
                end
                ostw_pkg::OP_I_INC:
                begin
                    i_reg <= i_reg + (BW+1)'(1);
                end
                ostw_pkg::OP_HYP_INIT:
                begin
                    k_reg <= '0;
                end
                ostw_pkg::OP_SCORE:
                begin
                    k_reg <= k_reg + (MW+1)'(1);
                end
                ostw_pkg::OP_HYP_END:
                begin
                    found_reg <= 1'b1;
                    i_reg     <= i_reg + (BW+1)'(1);
                end
                ostw_pkg::OP_COMMIT:
                begin
                    if (found_reg)
                    begin
                        winner_reg     <= best_idx_reg;
                        match_time_reg <= best_t_reg;
                        change_reg     <= now_reg;
                        re_reg         <= 1'b1;
                    end
                end
                ostw_pkg::OP_RESULT:
                begin
                    prev_reg    <= pitch_reg;
                    out_valid   <= 1'b1;
                    warped_time <= w_sat;
                    realigned   <= re_reg;
                    match_index <= 8'(winner_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
